// File: sv/twdp_pkg.sv
// Shared types and constants for the ternary-weight dot product.
// Used by twdp_front, twdp_queue, twdp_back and the top level.
// Depends on nothing.
package twdp_pkg;

  localparam int BLOCK_ELEMENTS  = 64;
  localparam int ACT_BITS        = 16;
  localparam int ACT_FIELD_W     = 16;
  localparam int BYTES_PER_BLOCK = (BLOCK_ELEMENTS + 3) / 4;
  localparam int POS_W           = (BYTES_PER_BLOCK > 1) ? $clog2(BYTES_PER_BLOCK) : 1;
  // Block sum holds up to 4 * BYTES_PER_BLOCK activations plus a sign bit.
  localparam int BACC_W          = ACT_BITS + $clog2(4 * BYTES_PER_BLOCK) + 1;
  localparam int HALF_W          = 16;
  localparam int SIG_W           = 11;
  localparam int PROD_W          = BACC_W + SIG_W;
  localparam int SUM_W           = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  // Ternary weight codes; all others mean zero.
  localparam logic [1:0] CODE_PLUS  = 2'd1;
  localparam logic [1:0] CODE_MINUS = 2'd2;

  // Half-precision field masks.
  localparam logic [4:0] EXP_ALL_ONES = 5'h1F;
  localparam logic [4:0] EXP_ZERO     = 5'h00;

  localparam logic [SUM_W-1:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

  // One closed block travelling from front to back.
  typedef struct packed {
    logic signed [BACC_W-1:0] acc;
    logic [HALF_W-1:0]        scale;
    logic                     last;
  } blk_t;

  // One finished row.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
    logic                    bad;
  } res_t;

endpackage

// File: sv/ternary_weight_dot_product.sv
// Ternary-weight block-scaled dot product over one row. One word (a packed
// byte of four 2-bit weights, four activations, a half-precision scale and
// a row_end mark) is taken per clock whenever full is low. The front adds
// or subtracts activations into a block sum and closes a block every 16
// words or on row_end; a four-entry queue carries closed blocks to the back,
// which decodes the scale, multiplies (one 23 x 11 multiplier), shifts,
// clips and adds into a saturating 64-bit row sum with 24 fractional bits.
// The back accepts one block per clock unless a full result buffer stalls it,
// so the sustained rate is one word per clock. A row result passes through
// the queue, the back stages and a two-word buffer absorbing reader stalls.
// Depends on twdp_pkg, twdp_front, twdp_queue and twdp_back.
module ternary_weight_dot_product (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [7:0]                             weight_byte,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_a,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_b,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_c,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_d,
  input  logic [twdp_pkg::HALF_W-1:0]            scale_half,
  input  logic                                   row_end,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [twdp_pkg::SUM_W-1:0]      dot_sum,
  output logic                                   saturated,
  output logic                                   bad_scale
);

  logic            accept;
  logic            blk_push;
  twdp_pkg::blk_t  blk_wdata;
  twdp_pkg::blk_t  blk_rdata;
  logic            blk_pop;
  logic            blk_empty;
  twdp_pkg::res_t  res_data;

  // Take a word only when the block queue has room
  assign accept = push & ~full;

  twdp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .weight_byte (weight_byte),
    .act_a       (act_a),
    .act_b       (act_b),
    .act_c       (act_c),
    .act_d       (act_d),
    .scale_half  (scale_half),
    .row_end     (row_end),
    .blk_push    (blk_push),
    .blk_data    (blk_wdata)
  );

  twdp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (blk_push),
    .wdata (blk_wdata),
    .full  (full),
    .pop   (blk_pop),
    .rdata (blk_rdata),
    .empty (blk_empty)
  );

  twdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .blk_data  (blk_rdata),
    .blk_empty (blk_empty),
    .blk_pop   (blk_pop),
    .res_data  (res_data),
    .res_empty (empty),
    .res_pop   (pop)
  );

  // Present the oldest finished row
  assign dot_sum   = res_data.sum;
  assign saturated = res_data.sat;
  assign bad_scale = res_data.bad;

endmodule

// File: sv/twdp_queue.sv
// Short queue of closed blocks between the front and back parts.
// Depends on twdp_pkg (blk_t, QUEUE_DEPTH).
module twdp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  twdp_pkg::blk_t  wdata,
  output logic            full,
  input  logic            pop,
  output twdp_pkg::blk_t  rdata,
  output logic            empty
);

  twdp_pkg::blk_t                 mem [twdp_pkg::QUEUE_DEPTH];
  logic [twdp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [twdp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [twdp_pkg::QPTR_W:0]      count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == (twdp_pkg::QPTR_W + 1)'(twdp_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + twdp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + twdp_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (twdp_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (twdp_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: sv/twdp_front.sv
// Front part: accepts input words, applies ternary codes to the block sum
// and hands each closed block to the queue. Depends on twdp_pkg.
module twdp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [7:0]                         weight_byte,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_a,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_b,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_c,
  input  logic signed [twdp_pkg::ACT_FIELD_W-1:0] act_d,
  input  logic [twdp_pkg::HALF_W-1:0]        scale_half,
  input  logic                               row_end,
  output logic                               blk_push,
  output twdp_pkg::blk_t                     blk_data
);

  logic [twdp_pkg::POS_W-1:0]          byte_position;
  logic signed [twdp_pkg::BACC_W-1:0]  block_accumulator;
  logic signed [twdp_pkg::BACC_W-1:0]  sum_next;
  logic signed [twdp_pkg::BACC_W-1:0]  act_ext [4];
  logic [twdp_pkg::ACT_FIELD_W-1:0]    act_raw [4];
  logic                                closes;

  // Sign-extend the low ACT_BITS of each activation field
  always_comb begin
    act_raw[0] = act_a;
    act_raw[1] = act_b;
    act_raw[2] = act_c;
    act_raw[3] = act_d;
    for (int k = 0; k < 4; k++) begin
      act_ext[k] = twdp_pkg::BACC_W'(signed'(act_raw[k][twdp_pkg::ACT_BITS-1:0]));
    end
  end

  // Add or subtract each activation by its code
  always_comb begin
    sum_next = block_accumulator;
    for (int k = 0; k < 4; k++) begin
      case (weight_byte[2*k +: 2])
        twdp_pkg::CODE_PLUS:  sum_next = sum_next + act_ext[k];
        twdp_pkg::CODE_MINUS: sum_next = sum_next - act_ext[k];
        default:              sum_next = sum_next;
      endcase
    end
  end

  assign closes = row_end |
                  (byte_position == twdp_pkg::POS_W'(twdp_pkg::BYTES_PER_BLOCK - 1));

  // Hand a closed block to the queue
  assign blk_push       = accept & closes;
  assign blk_data.acc   = sum_next;
  assign blk_data.scale = scale_half;
  assign blk_data.last  = row_end;

  // Hold the running block sum and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      block_accumulator <= '0;
    end else if (accept) begin
      if (closes) begin
        byte_position     <= '0;
        block_accumulator <= '0;
      end else begin
        byte_position     <= byte_position + twdp_pkg::POS_W'(1);
        block_accumulator <= sum_next;
      end
    end
  end

endmodule

// File: sv/twdp_back.sv
// Back part: scales each closed block by its half-precision scale, adds it
// into the saturating row sum and buffers finished rows.
// Depends on twdp_pkg.
module twdp_back (
  input  logic            clk,
  input  logic            rst,
  input  twdp_pkg::blk_t  blk_data,
  input  logic            blk_empty,
  output logic            blk_pop,
  output twdp_pkg::res_t  res_data,
  output logic            res_empty,
  input  logic            res_pop
);

  localparam int SUM_W = twdp_pkg::SUM_W;

  // Stage 1: decoded scale and block magnitude
  logic                              s1_valid;
  logic [twdp_pkg::BACC_W-1:0]       s1_amag;
  logic [twdp_pkg::SIG_W-1:0]        s1_sig;
  logic [4:0]                        s1_shift;
  logic                              s1_neg;
  logic                              s1_bad;
  logic                              s1_last;
  // Stage 2: product
  logic                              s2_valid;
  logic [twdp_pkg::PROD_W-1:0]       s2_prod;
  logic [4:0]                        s2_shift;
  logic                              s2_neg;
  logic                              s2_bad;
  logic                              s2_last;
  // Stage 3: signed term
  logic                              s3_valid;
  logic [SUM_W-1:0]                  s3_term;
  logic                              s3_clip;
  logic                              s3_bad;
  logic                              s3_last;

  logic [SUM_W-1:0]                  row_accumulator;
  logic                              saturate_seen;
  logic                              bad_scale_seen;

  twdp_pkg::res_t                    out_mem [2];
  logic                              out_wr;
  logic                              out_rd;
  logic [1:0]                        out_count;

  logic                              adv;
  logic                              row_done;
  logic                              out_pop;

  logic [4:0]                        d_expo;
  logic                              d_neg_acc;
  logic [twdp_pkg::BACC_W-1:0]       d_amag;
  logic [SUM_W-1:0]                  t_limit;
  logic [SUM_W-1:0]                  t_wide;
  logic [SUM_W-1:0]                  t_mag;
  logic                              t_over;
  logic [SUM_W-1:0]                  r_sum;
  logic                              r_ovf;
  logic [SUM_W-1:0]                  r_next;

  // Stall the whole back part only when a finished row has nowhere to go
  assign row_done = s3_valid & s3_last;
  assign adv      = ~(row_done & (out_count == 2'd2));
  assign blk_pop  = adv & ~blk_empty;

  // Decode the scale and take the block magnitude
  always_comb begin
    d_expo    = blk_data.scale[14:10];
    d_neg_acc = blk_data.acc[twdp_pkg::BACC_W-1];
    d_amag    = d_neg_acc ? (~blk_data.acc + twdp_pkg::BACC_W'(1)) : blk_data.acc;
  end

  // Shift the product and clip to the signed range
  always_comb begin
    t_limit = s2_neg ? twdp_pkg::LIMIT_NEG : twdp_pkg::LIMIT_POS;
    t_wide  = SUM_W'(s2_prod);
    t_over  = t_wide > (t_limit >> s2_shift);
    t_mag   = t_over ? t_limit : (t_wide << s2_shift);
  end

  // Saturating add into the row sum
  always_comb begin
    r_sum  = row_accumulator + s3_term;
    r_ovf  = (row_accumulator[SUM_W-1] == s3_term[SUM_W-1]) &&
             (r_sum[SUM_W-1] != row_accumulator[SUM_W-1]);
    r_next = r_ovf ? (row_accumulator[SUM_W-1] ? twdp_pkg::LIMIT_NEG : twdp_pkg::LIMIT_POS)
                   : r_sum;
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_amag  <= d_amag;
      s1_sig   <= {(d_expo != twdp_pkg::EXP_ZERO), blk_data.scale[9:0]};
      s1_shift <= (d_expo == twdp_pkg::EXP_ZERO) ? 5'd0 : (d_expo - 5'd1);
      s1_neg   <= d_neg_acc ^ blk_data.scale[15];
      s1_bad   <= (d_expo == twdp_pkg::EXP_ALL_ONES);
      s1_last  <= blk_data.last;

      s2_prod  <= twdp_pkg::PROD_W'(s1_amag) * twdp_pkg::PROD_W'(s1_sig);
      s2_shift <= s1_shift;
      s2_neg   <= s1_neg;
      s2_bad   <= s1_bad;
      s2_last  <= s1_last;

      s3_term  <= s2_bad ? '0 : (s2_neg ? (~t_mag + SUM_W'(1)) : t_mag);
      s3_clip  <= ~s2_bad & t_over;
      s3_bad   <= s2_bad;
      s3_last  <= s2_last;
    end
  end

  // Pipeline valid bits and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      row_accumulator <= '0;
      saturate_seen   <= 1'b0;
      bad_scale_seen  <= 1'b0;
    end else if (adv) begin
      s1_valid <= ~blk_empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (s3_valid) begin
        if (s3_last) begin
          row_accumulator <= '0;
          saturate_seen   <= 1'b0;
          bad_scale_seen  <= 1'b0;
        end else begin
          row_accumulator <= r_next;
          saturate_seen   <= saturate_seen | s3_clip | r_ovf;
          bad_scale_seen  <= bad_scale_seen | s3_bad;
        end
      end
    end
  end

  // Result buffer: two words, so the row sum waits only when both are unread
  assign out_pop   = res_pop & ~res_empty;
  assign res_empty = (out_count == 2'd0);
  assign res_data  = out_mem[out_rd];

  always_ff @(posedge clk) begin
    if (adv && row_done) begin
      out_mem[out_wr].sum <= r_next;
      out_mem[out_wr].sat <= saturate_seen | s3_clip | r_ovf;
      out_mem[out_wr].bad <= bad_scale_seen | s3_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (adv && row_done) begin
        out_wr <= ~out_wr;
      end
      if (out_pop) begin
        out_rd <= ~out_rd;
      end
      if ((adv && row_done) && !out_pop) begin
        out_count <= out_count + 2'd1;
      end else if (out_pop && !(adv && row_done)) begin
        out_count <= out_count - 2'd1;
      end
    end
  end

endmodule

// File: tb/ternary_weight_dot_product_test.sv
`timescale 1ns / 100ps
// Testbench for ternary_weight_dot_product: directed and random rows of weight words,
// each result row checked against an in-bench predictor held in a scoreboard class.
// Depends on twdp_pkg and the ternary_weight_dot_product RTL.
module ternary_weight_dot_product_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_WORDS  = 900;
  localparam int PRESSURE_AT   = 450;
  localparam int CALM_AT       = 780;
  localparam int DRAIN_CYCLES  = 8;

  // One input word as driven on the ports; act[0] goes with bits 1:0.
  typedef struct {
    logic [7:0]       weight;
    logic [3:0][15:0] act;
    logic [15:0]      scale;
    logic             row_end;
  } word_t;

  // Predicts row sums from accepted words and checks rows as they are popped.
  class dot_row_scoreboard;
    twdp_pkg::res_t expected_rows[$];
    int      position;
    longint  block_sum;
    bit [63:0] row_sum;
    bit      clip_seen;
    bit      nan_seen;
    int      errors;
    int      rows_checked;
    int      clipped_rows;
    int      bad_rows;

    function void note_word(word_t w);
      bit [1:0]  code;
      longint    a;
      bit [4:0]  ex;
      bit [63:0] sig, amag, prod, lim, mag, term, r;
      int        shamt;
      bit        neg;
      twdp_pkg::res_t row;

      // add or subtract each activation into the block sum
      for (int k = 0; k < 4; k++) begin
        code = w.weight[2*k +: 2];
        a = longint'($signed(w.act[k]));
        if (code == twdp_pkg::CODE_PLUS) block_sum += a;
        else if (code == twdp_pkg::CODE_MINUS) block_sum -= a;
      end

      // close the block: scale exactly, clip, and add into the row sum
      if (w.row_end || position + 1 >= twdp_pkg::BYTES_PER_BLOCK) begin
        ex = w.scale[14:10];
        if (ex == twdp_pkg::EXP_ALL_ONES) begin
          nan_seen = 1'b1;
        end else begin
          amag = (block_sum < 0) ? 64'(-block_sum) : 64'(block_sum);
          if (ex == twdp_pkg::EXP_ZERO) begin
            sig = {54'd0, w.scale[9:0]};
            shamt = 0;
          end else begin
            sig = {53'd0, 1'b1, w.scale[9:0]};
            shamt = int'(ex) - 1;
          end
          prod = amag * sig;
          if (prod != 0) begin
            neg = (block_sum < 0) != w.scale[15];
            lim = neg ? twdp_pkg::LIMIT_NEG : twdp_pkg::LIMIT_POS;
            if (prod > (lim >> shamt)) begin
              clip_seen = 1'b1;
              mag = lim;
            end else begin
              mag = prod << shamt;
            end
            term = neg ? (64'd0 - mag) : mag;
            r = row_sum + term;
            if (row_sum[63] == term[63] && r[63] != row_sum[63]) begin
              clip_seen = 1'b1;
              r = row_sum[63] ? twdp_pkg::LIMIT_NEG : twdp_pkg::LIMIT_POS;
            end
            row_sum = r;
          end
        end
        block_sum = 0;
        position = 0;
      end else begin
        position++;
      end

      // row end: queue the expected row and clear for the next one
      if (w.row_end) begin
        row.sum = row_sum;
        row.sat = clip_seen;
        row.bad = nan_seen;
        expected_rows.push_back(row);
        row_sum = '0;
        clip_seen = 1'b0;
        nan_seen = 1'b0;
      end
    endfunction

    function void check_row(logic signed [63:0] sum, logic sat, logic bad);
      twdp_pkg::res_t want;

      if (expected_rows.size() == 0) begin
        $error("dot_sum: expected no row, got %0d", sum);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (want.sat) clipped_rows++;
      if (want.bad) bad_rows++;
      if (sum !== want.sum) begin
        $error("dot_sum: expected %0d, got %0d", want.sum, sum);
        errors++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, sat);
        errors++;
      end
      if (bad !== want.bad) begin
        $error("bad_scale: expected %0b, got %0b", want.bad, bad);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic [7:0]              weight_byte = '0;
  logic signed [15:0]      act_a = '0;
  logic signed [15:0]      act_b = '0;
  logic signed [15:0]      act_c = '0;
  logic signed [15:0]      act_d = '0;
  logic [15:0]             scale_half = '0;
  logic                    row_end = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [63:0]      dot_sum;
  logic                    saturated;
  logic                    bad_scale;

  dot_row_scoreboard sb = new();
  int  words_sent;
  int  cycle_count;
  bit  calm;
  bit  reset_done;

  ternary_weight_dot_product u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .weight_byte (weight_byte),
    .act_a       (act_a),
    .act_b       (act_b),
    .act_c       (act_c),
    .act_d       (act_d),
    .scale_half  (scale_half),
    .row_end     (row_end),
    .empty       (empty),
    .pop         (pop),
    .dot_sum     (dot_sum),
    .saturated   (saturated),
    .bad_scale   (bad_scale)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(word_t w);
    push        <= 1'b1;
    weight_byte <= w.weight;
    act_a       <= w.act[0];
    act_b       <= w.act[1];
    act_c       <= w.act[2];
    act_d       <= w.act[3];
    scale_half  <= w.scale;
    row_end     <= w.row_end;
    do @(posedge clk); while (full);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic hold_off(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send a row of n words; a heavy row drives full-scale sums to push the row sum to its limit.
  task automatic run_row(int n, bit heavy, bit neg);
    word_t w;

    for (int i = 0; i < n; i++) begin
      if (heavy) begin
        w.weight = 8'h55;
        for (int k = 0; k < 4; k++) w.act[k] = neg ? 16'h8000 : 16'h7FFF;
        w.scale = 16'h7BFF;
      end else begin
        w.weight = 8'($urandom_range(0, 255));
        for (int k = 0; k < 4; k++) w.act[k] = 16'($urandom_range(0, 65535));
        w.scale = 16'($urandom_range(0, 65535));
        // keep most scales finite so that most rows carry a real sum
        if (w.scale[14:10] == twdp_pkg::EXP_ALL_ONES && $urandom_range(0, 3) != 0)
          w.scale[14] = 1'b0;
      end
      w.row_end = (i == n - 1);
      send_word(w);
      if (!calm && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 3));
    end
  endtask

  task automatic send_single(logic [7:0] wt, logic [15:0] a0, logic [15:0] a1,
                             logic [15:0] a2, logic [15:0] a3, logic [15:0] sc);
    word_t w;

    w.weight  = wt;
    w.act     = {a3, a2, a1, a0};
    w.scale   = sc;
    w.row_end = 1'b1;
    send_word(w);
  endtask

  // Pop results with random stall bursts and check each row taken.
  initial begin
    int stall_left;

    stall_left = 0;
    wait (reset_done);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_row(dot_sum, saturated, bad_scale);
      if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Bound the run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int  n;
    int  pick;
    bit  paused;

    paused = 1'b0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;
    @(posedge clk);

    // single-word rows: weight code mixes, activation extremes, special scales
    send_single(8'h55, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h3C00);
    send_single(8'hAA, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7BFF);
    send_single(8'hE4, 16'h04D2, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
    send_single(8'hFF, 16'h1234, 16'h8001, 16'h7FFE, 16'h0001, 16'h8000);
    send_single(8'h00, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
    send_single(8'h1B, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h7C00);
    send_single(8'h66, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000, 16'hFE01);
    send_single(8'h55, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h83FF);
    // row end on the last word of a full block
    run_row(twdp_pkg::BYTES_PER_BLOCK, 1'b1, 1'b1);

    // random rows: mostly short, some whole blocks, a few long full-scale rows
    while (words_sent < RANDOM_WORDS) begin
      if (!paused && words_sent >= PRESSURE_AT) begin
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        paused = 1'b1;
      end
      calm = (words_sent >= CALM_AT);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        run_row($urandom_range(5 * twdp_pkg::BYTES_PER_BLOCK, 7 * twdp_pkg::BYTES_PER_BLOCK),
                1'b1, 1'($urandom_range(0, 1)));
      end else if (pick < 4) begin
        n = twdp_pkg::BYTES_PER_BLOCK * $urandom_range(1, 3);
        run_row(n, 1'b0, 1'b0);
      end else begin
        run_row($urandom_range(1, 40), 1'b0, 1'b0);
      end
    end
    push <= 1'b0;

    // drain, then allow the pipeline to settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words in %0d rows; %0d rows clipped, %0d rows saw an inf/NaN scale.",
             words_sent, sb.rows_checked, sb.clipped_rows, sb.bad_rows);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/twdp_pkg.sv
sv/twdp_queue.sv
sv/twdp_front.sv
sv/twdp_back.sv
sv/ternary_weight_dot_product.sv
tb/ternary_weight_dot_product_test.sv
